// ===== design/gdd_pkg.sv =====
// Shared widths, result type and calendar helper functions for the date difference unit.
package gdd_pkg;

  localparam int YEAR_BITS  = 14;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int DIFF_BITS  = 23;
  // Day count since 0001-01-01 needs about nine bits more than the year
  localparam int CNT_BITS   = YEAR_BITS + 9;
  // Quotient widths for year/100 and year/400
  localparam int Q100_BITS  = YEAR_BITS - 6;
  localparam int Q400_BITS  = YEAR_BITS - 8;
  // Reciprocal of 25 scaled by 2^20, rounded up
  localparam int DIV25_SHIFT = 20;
  localparam int DIV25_MUL   = 41944;

  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);

  // One lane's result: date is valid, and its day number
  typedef struct packed {
    logic                ok;
    logic [CNT_BITS-1:0] num;
  } lane_res_t;

  // Divide by 25 through a scaled reciprocal; exact for every input of its YEAR_BITS-2 bit width
  function automatic logic [Q100_BITS-1:0] div_by_25(input logic [YEAR_BITS-3:0] x);
    logic [YEAR_BITS+13:0] prod;
    prod = (YEAR_BITS+14)'(x) * (YEAR_BITS+14)'(DIV25_MUL);
    return prod[YEAR_BITS+13:DIV25_SHIFT];
  endfunction

  // Days before the first of each month in a common year
  function automatic logic [8:0] days_before_month(input logic [MONTH_BITS-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month, with February following the leap flag
  function automatic logic [DAY_BITS-1:0] month_length(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
    logic [DAY_BITS-1:0] r;
    if (m == MONTH_FEB) begin
      r = leap ? DAY_BITS'(29) : DAY_BITS'(28);
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      r = DAY_BITS'(30);
    end else begin
      r = DAY_BITS'(31);
    end
    return r;
  endfunction

endpackage

// ===== design/gdd_lane.sv =====
// One date lane: validity check and day number since 0001-01-01, three register stages.
module gdd_lane import gdd_pkg::*; (
  input  logic                  clk,
  input  logic [YEAR_BITS-1:0]  year,
  input  logic [MONTH_BITS-1:0] month,
  input  logic [DAY_BITS-1:0]   day,
  output lane_res_t             res
);

  // Stage 1 registers
  logic [YEAR_BITS-1:0]  py1;
  logic [MONTH_BITS-1:0] m1;
  logic [DAY_BITS-1:0]   d1;
  logic                  yz1;
  logic [CNT_BITS-1:0]   p365_1;
  logic [Q100_BITS-1:0]  q100_1;
  logic [Q400_BITS-1:0]  q400_1;

  // Stage 2 registers
  logic [MONTH_BITS-1:0] m2;
  logic [DAY_BITS-1:0]   d2;
  logic                  ok2;
  logic                  leap2;
  logic [CNT_BITS-1:0]   base2;

  // Stage 2 logic
  logic [YEAR_BITS-1:0]  py_in;
  logic [YEAR_BITS-1:0]  r100;
  logic [YEAR_BITS-1:0]  r400;
  logic                  leap;
  logic                  ok_next;
  logic [CNT_BITS-1:0]   base_next;
  logic [CNT_BITS-1:0]   num_next;
  logic                  late_leap;

  assign py_in = year - YEAR_BITS'(1);

  // Stage 1: elapsed years, their day product and the century quotients
  always_ff @(posedge clk) begin
    py1    <= py_in;
    m1     <= month;
    d1     <= day;
    yz1    <= (year == '0);
    p365_1 <= CNT_BITS'(py_in) * CNT_BITS'(365);
    q100_1 <= div_by_25(py_in[YEAR_BITS-1:2]);
    q400_1 <= Q400_BITS'(div_by_25((YEAR_BITS-2)'(py_in[YEAR_BITS-1:4])));
  end

  // Leap test on y = py + 1: y%100 == 0 exactly when py%100 == 99
  assign r100 = py1 - YEAR_BITS'(YEAR_BITS'(q100_1) * YEAR_BITS'(100));
  assign r400 = py1 - YEAR_BITS'(YEAR_BITS'(q400_1) * YEAR_BITS'(400));
  assign leap = ((py1[1:0] == 2'b11) && (r100 != YEAR_BITS'(99)))
             || (r400 == YEAR_BITS'(399));

  assign ok_next = !yz1 && (m1 inside {[4'd1:4'd12]}) && (d1 != '0)
                && (d1 <= month_length(m1, leap));

  assign base_next = p365_1 + CNT_BITS'(py1[YEAR_BITS-1:2])
                   - CNT_BITS'(q100_1) + CNT_BITS'(q400_1);

  // Stage 2: hold validity, leap flag and whole-year day base
  always_ff @(posedge clk) begin
    m2    <= m1;
    d2    <= d1;
    ok2   <= ok_next;
    leap2 <= leap;
    base2 <= base_next;
  end

  // Stage 3: add days within the year
  assign late_leap = leap2 && (m2 > MONTH_FEB);
  assign num_next  = base2 + CNT_BITS'(days_before_month(m2)) + CNT_BITS'(late_leap)
                   + CNT_BITS'(d2) - CNT_BITS'(1);

  always_ff @(posedge clk) begin
    res.ok  <= ok2;
    res.num <= num_next;
  end

endmodule

// ===== design/gdd_merge.sv =====
// Merge stage: absolute difference of the two lane day numbers, gated by validity.
module gdd_merge import gdd_pkg::*; (
  input  logic                 clk,
  input  lane_res_t            res_a,
  input  lane_res_t            res_b,
  output logic                 both_valid,
  output logic [DIFF_BITS-1:0] day_difference
);

  logic                both_ok;
  logic [CNT_BITS-1:0] diff;

  // Subtract the smaller count from the larger
  assign both_ok = res_a.ok && res_b.ok;
  assign diff    = (res_a.num >= res_b.num) ? (res_a.num - res_b.num)
                                            : (res_b.num - res_a.num);

  // Wrap the difference to the result width
  always_ff @(posedge clk) begin
    both_valid     <= both_ok;
    day_difference <= both_ok ? DIFF_BITS'(diff) : '0;
  end

endmodule

// ===== design/gregorian_date_difference_unit.sv =====
// Top level of the date difference unit: two date lanes, merge stage and strobe pipeline.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+--------------------------
//  input   | year_a month_a day_a year_b month_b day_b      | start high, busy low
//  output  | both_valid day_difference                      | done high for one cycle
//
// Each accepted transaction reaches its done strobe through
// three stages in each date lane and one in the merge stage.
// A new transaction may be started every cycle; busy stays low.
// Synchronous reset clears the strobe pipeline only; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module gregorian_date_difference_unit import gdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [YEAR_BITS-1:0]  year_a,
  input  logic [MONTH_BITS-1:0] month_a,
  input  logic [DAY_BITS-1:0]   day_a,
  input  logic [YEAR_BITS-1:0]  year_b,
  input  logic [MONTH_BITS-1:0] month_b,
  input  logic [DAY_BITS-1:0]   day_b,
  output logic                  done,
  output logic                  both_valid,
  output logic [DIFF_BITS-1:0]  day_difference
);

  localparam int LATENCY = 4;

  lane_res_t          res_a;
  lane_res_t          res_b;
  logic [LATENCY-1:0] vpipe;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // One lane per date
  gdd_lane u_lane_a (
    .clk   (clk),
    .year  (year_a),
    .month (month_a),
    .day   (day_a),
    .res   (res_a)
  );

  gdd_lane u_lane_b (
    .clk   (clk),
    .year  (year_b),
    .month (month_b),
    .day   (day_b),
    .res   (res_b)
  );

  // Combine lane results
  gdd_merge u_merge (
    .clk            (clk),
    .res_a          (res_a),
    .res_b          (res_b),
    .both_valid     (both_valid),
    .day_difference (day_difference)
  );

  // Advance the transaction strobe alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], accept};
    end
  end

  assign done = vpipe[LATENCY-1];

  // Each strobe traces back to an earlier accepted transaction
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("done without an accepted transaction");

  // Invalid results carry a zero difference
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !both_valid) |-> (day_difference == '0))
    else $error("nonzero difference on invalid result");

  // Year zero is never valid
  a_year_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(year_a == '0 || year_b == '0, LATENCY)) |-> !both_valid)
    else $error("year zero reported valid");

  // Identical dates give a zero difference
  a_same_date: assert property (@(posedge clk) disable iff (rst)
    (done && $past(year_a == year_b && month_a == month_b && day_a == day_b, LATENCY))
      |-> (day_difference == '0))
    else $error("identical dates gave nonzero difference");

endmodule
